// ===== rtl/b32e_pkg.sv =====
// b32e_pkg: shared types, constants and the character map of the base32 encoder
// used by b32e_front, b32e_fifo, b32e_back and base32_encoder_wrapped
`timescale 1ns / 1ps
`default_nettype none

package b32e_pkg;

  localparam int unsigned GroupBits = 40;
  localparam int unsigned WrapW     = 10;
  localparam int unsigned QueueAw   = 1;

  localparam logic [WrapW-1:0] WrapReset = 10'd76;

  localparam logic [7:0] PadChar     = 8'h3D;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] UpperA      = 8'h41;
  localparam logic [7:0] DigitTwo    = 8'h32;

  // one group handed from the front to the back
  typedef struct packed {
    logic [GroupBits-1:0] grp;
    logic [3:0]           nchars;
    logic                 last;
  } job_t;

  typedef enum logic [1:0] {
    ST_CHAR,
    ST_WRAP_NL,
    ST_END_NL
  } back_state_t;

  function automatic logic [7:0] b32_char(input logic [4:0] idx);
    logic [7:0] ch;
    if (idx < 5'd26) begin
      ch = UpperA + {3'd0, idx};
    end else begin
      ch = DigitTwo + {3'd0, idx - 5'd26};
    end
    return ch;
  endfunction

  function automatic logic [3:0] chars_for(input logic [2:0] held);
    logic [3:0] n;
    case (held)
      3'd0:    n = 4'd2;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd5;
      3'd3:    n = 4'd7;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b32e_front.sv =====
// b32e_front: takes bytes, gathers groups of up to five (fewer at end of data) and issues one job per group
// depends on b32e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b32e_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output b32e_pkg::job_t       q_job
);

  logic [7:0] gb_r [4];
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       accept;
  logic       complete;
  logic [7:0] g [5];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign complete = (cnt_r == 3'd4) || in_end_of_data;
  assign q_push   = accept && complete;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt_r) begin
        g[i] = gb_r[i];
      end else if (3'(i) == cnt_r) begin
        g[i] = in_data_byte;
      end else begin
        g[i] = 8'd0;
      end
    end
    g[4] = (cnt_r == 3'd4) ? in_data_byte : 8'd0;
  end

  always_comb begin
    q_job.grp    = {g[0], g[1], g[2], g[3], g[4]};
    q_job.nchars = b32e_pkg::chars_for(cnt_r);
    q_job.last   = in_end_of_data;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = complete ? 3'd0 : cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      gb_r[cnt_r[1:0]] <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b32e_fifo.sv =====
// b32e_fifo: two-entry job queue between front and back
// depends on b32e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b32e_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b32e_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 nonempty,
  output b32e_pkg::job_t       head_job
);

  localparam int unsigned Depth = 2 ** b32e_pkg::QueueAw;

  b32e_pkg::job_t                mem_r [Depth];
  logic [b32e_pkg::QueueAw-1:0]  wp_r;
  logic [b32e_pkg::QueueAw-1:0]  rp_r;
  logic [b32e_pkg::QueueAw:0]    cnt_r;
  logic [b32e_pkg::QueueAw:0]    cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (cnt_r == (b32e_pkg::QueueAw + 1)'(Depth));
  assign nonempty = (cnt_r != '0);
  assign head_job = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b32e_back.sv =====
// b32e_back: turns one job into characters, padding and newlines, one per cycle unless the output stalls
// depends on b32e_pkg; holds the wrap register and the column counter
`timescale 1ns / 1ps
`default_nettype none

module b32e_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [b32e_pkg::WrapW-1:0]    cfg_wr_data,
  input  wire logic                          job_valid,
  input  wire b32e_pkg::job_t                job,
  output logic                               job_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_char,
  output logic                               out_last_of_run
);

  logic [b32e_pkg::WrapW-1:0] wrap_r;
  logic [b32e_pkg::WrapW-1:0] col_r;
  logic [b32e_pkg::WrapW-1:0] col_nxt;
  logic [b32e_pkg::WrapW-1:0] col_inc;
  logic [b32e_pkg::WrapW-1:0] col_after;
  logic [2:0]                 idx_r;
  logic [2:0]                 idx_nxt;
  b32e_pkg::back_state_t      st_r;
  b32e_pkg::back_state_t      st_nxt;
  logic                       ovalid_r;
  logic [7:0]                 ochar_r;
  logic                       olast_r;
  logic                       fire;
  logic                       wrap_on;
  logic                       wrap_hit;
  logic [4:0]                 sym;
  logic [7:0]                 ch;
  logic                       is_last;

  assign out_valid       = ovalid_r;
  assign out_char        = ochar_r;
  assign out_last_of_run = olast_r;

  assign fire      = job_valid && (!ovalid_r || out_ready);
  assign wrap_on   = (wrap_r != '0);
  assign col_inc   = col_r + 1'b1;
  assign wrap_hit  = wrap_on && (col_inc >= wrap_r);
  assign col_after = wrap_on ? col_inc : col_r;

  always_comb begin
    case (idx_r)
      3'd0:    sym = job.grp[39:35];
      3'd1:    sym = job.grp[34:30];
      3'd2:    sym = job.grp[29:25];
      3'd3:    sym = job.grp[24:20];
      3'd4:    sym = job.grp[19:15];
      3'd5:    sym = job.grp[14:10];
      3'd6:    sym = job.grp[9:5];
      default: sym = job.grp[4:0];
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    col_nxt = col_r;
    is_last = 1'b0;
    ch      = b32e_pkg::NewlineChar;
    case (st_r)
      b32e_pkg::ST_CHAR: begin
        ch = ({1'b0, idx_r} < job.nchars) ? b32e_pkg::b32_char(sym) : b32e_pkg::PadChar;
        if (wrap_hit) begin
          col_nxt = '0;
          st_nxt  = b32e_pkg::ST_WRAP_NL;
        end else if (idx_r == 3'd7) begin
          if (job.last && (!wrap_on || col_after != '0)) begin
            col_nxt = col_after;
            st_nxt  = b32e_pkg::ST_END_NL;
          end else begin
            is_last = 1'b1;
            col_nxt = job.last ? '0 : col_after;
            idx_nxt = 3'd0;
          end
        end else begin
          col_nxt = col_after;
          idx_nxt = idx_r + 3'd1;
        end
      end
      b32e_pkg::ST_WRAP_NL: begin
        col_nxt = '0;
        st_nxt  = b32e_pkg::ST_CHAR;
        if (idx_r == 3'd7) begin
          is_last = 1'b1;
          idx_nxt = 3'd0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      b32e_pkg::ST_END_NL: begin
        col_nxt = '0;
        is_last = 1'b1;
        idx_nxt = 3'd0;
        st_nxt  = b32e_pkg::ST_CHAR;
      end
      default: begin
        st_nxt  = b32e_pkg::ST_CHAR;
        idx_nxt = 3'd0;
      end
    endcase
  end

  assign job_pop = fire && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r   <= b32e_pkg::WrapReset;
      col_r    <= '0;
      idx_r    <= 3'd0;
      st_r     <= b32e_pkg::ST_CHAR;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wrap_r <= cfg_wr_data;
      end
      if (fire) begin
        col_r    <= col_nxt;
        idx_r    <= idx_nxt;
        st_r     <= st_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ochar_r <= ch;
      olast_r <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base32_encoder_wrapped.sv =====
// base32_encoder_wrapped: base32 encoder with line wrapping, top level
// depends on b32e_pkg, b32e_front, b32e_fifo, b32e_back
//
//   port group   direction  handshake          payload
//   in_          in         in_valid/in_ready  in_data_byte[7:0], in_end_of_data
//   out_         out        out_valid/out_ready out_char[7:0], out_last_of_run
//   cfg_         in         cfg_wr_en          cfg_wr_data[9:0] (wrap width)
//
// one byte is taken per cycle while the two-entry job queue has room
// the back end sends one character per cycle while a job is queued and the output
// is not stalled; a group of five bytes gives eight characters plus a newline at
// each wrap, and a final group ends with a newline unless a wrap newline just did
// out_ready low stalls the back end; the queue then fills and drops in_ready
// rst_n is synchronous; it sets the wrap width to 76 and empties all state
`timescale 1ns / 1ps
`default_nettype none

module base32_encoder_wrapped (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_end_of_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_char,
  output logic                             out_last_of_run,
  input  wire logic                        cfg_wr_en,
  input  wire logic [b32e_pkg::WrapW-1:0]  cfg_wr_data
);

  b32e_pkg::job_t push_job;
  b32e_pkg::job_t head_job;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;

  b32e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_data (in_end_of_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  b32e_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_job (head_job)
  );

  b32e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .job_valid       (q_nonempty),
    .job             (head_job),
    .job_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== dv/tb_base32_encoder_wrapped.sv =====
// tb_base32_encoder_wrapped: self-checking bench for the base32 encoder with line wrapping
// holds a scoreboard class that predicts the character stream from accepted bytes
// depends on b32e_pkg and base32_encoder_wrapped
`timescale 1ns / 1ps

module tb_base32_encoder_wrapped;

  localparam int QuietLimit = 4000;
  localparam int SettleCycles = 16;
  localparam int RandomItems = 425;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  class b32_scoreboard;
    logic [7:0]                 grp_bytes[4];
    int unsigned                held;
    logic [b32e_pkg::WrapW-1:0] col;
    logic [b32e_pkg::WrapW-1:0] wrap;
    enc_char_t                  expected_chars[$];
    int                         mismatches;

    function new();
      held = 0;
      col = '0;
      wrap = b32e_pkg::WrapReset;
      mismatches = 0;
    endfunction

    function void set_wrap(logic [b32e_pkg::WrapW-1:0] w);
      wrap = w;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void put_char(logic [7:0] ch);
      enc_char_t e;
      e.ch = ch;
      e.last = 1'b0;
      expected_chars.push_back(e);
      if (wrap != '0) begin
        col = col + 1'b1;
        if (col >= wrap) begin
          e.ch = b32e_pkg::NewlineChar;
          expected_chars.push_back(e);
          col = '0;
        end
      end
    endfunction

    // an item either extends the pending group or flushes it as eight characters and their newlines
    function void note_byte(logic [7:0] b, logic eod);
      logic [39:0] grp;
      int          nchars;
      logic [4:0]  idx;
      logic [7:0]  ch;
      enc_char_t   e;
      if (held < 4 && !eod) begin
        grp_bytes[held] = b;
        held++;
        return;
      end
      grp = '0;
      for (int i = 0; i < 4; i++) begin
        if (i < held) grp[39-8*i -: 8] = grp_bytes[i];
      end
      grp[39-8*held -: 8] = b;
      case (held)
        0: nchars = 2;
        1: nchars = 4;
        2: nchars = 5;
        3: nchars = 7;
        default: nchars = 8;
      endcase
      for (int i = 0; i < 8; i++) begin
        idx = grp[39-5*i -: 5];
        if (i >= nchars) ch = b32e_pkg::PadChar;
        else if (idx < 5'd26) ch = b32e_pkg::UpperA + idx;
        else ch = b32e_pkg::DigitTwo + (idx - 5'd26);
        put_char(ch);
      end
      held = 0;
      if (eod) begin
        if (wrap == '0 || col != '0) begin
          e.ch = b32e_pkg::NewlineChar;
          e.last = 1'b0;
          expected_chars.push_back(e);
        end
        col = '0;
      end
      expected_chars[expected_chars.size()-1].last = 1'b1;
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      enc_char_t e;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: char %h last %b", ch, last);
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== ch || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected char %h last %b, got char %h last %b",
                   e.ch, e.last, ch, last);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 in_data_byte;
  logic                       in_end_of_data;
  logic                       out_valid;
  logic                       out_ready;
  logic [7:0]                 out_char;
  logic                       out_last_of_run;
  logic                       cfg_wr_en;
  logic [b32e_pkg::WrapW-1:0] cfg_wr_data;

  b32_scoreboard sb;
  int quiet_cycles;
  int rx_mode, rx_left, rx_run;
  logic rx_hold;

  base32_encoder_wrapped uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_data  (in_end_of_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor, prediction and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_wrap(cfg_wr_data);
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_end_of_data);
      if (out_valid && out_ready) sb.check_char(out_char, out_last_of_run);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        rx_run--;
        out_ready <= rx_hold;
      end
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_wrap(input logic [b32e_pkg::WrapW-1:0] w);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [b32e_pkg::WrapW-1:0] rand_wrap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 10'd1;
      2: return 10'd2;
      3: return 10'd3;
      4: return 10'd8;
      5: return 10'd9;
      6: return 10'd1023;
      7: return b32e_pkg::WrapReset;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int stream_left, phase_left, burst_left, gap_max, len_pick;
    sb = new();
    quiet_cycles = 0;
    rx_mode = 0;
    rx_left = 0;
    rx_run = 0;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_data = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short final groups of every size and a full one, default wrap
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full group without end, then a lone final byte
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b1);
    // one character per line, the most results per item
    write_wrap(10'd1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h0F, 1'b1);

    // random streams; wrap changes land mid-stream and mid-line
    write_wrap(10'd1023);
    stream_left = 0;
    phase_left = $urandom_range(30, 70);
    burst_left = 0;
    gap_max = 4;
    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        write_wrap(rand_wrap());
        phase_left = $urandom_range(30, 70);
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (stream_left == 0) begin
        len_pick = $urandom_range(0, 19);
        if (len_pick < 14) stream_left = $urandom_range(1, 12);
        else if (len_pick < 19) stream_left = $urandom_range(13, 40);
        else stream_left = $urandom_range(41, 100);
      end
      if (burst_left == 0) begin
        pause_input(gap_max == 0 ? 0 : $urandom_range(0, gap_max));
        burst_left = $urandom_range(1, 24);
      end
      send_byte(rand_byte(), stream_left == 1);
      stream_left--;
      phase_left--;
      burst_left--;
    end
    // close any open stream so its group is flushed
    if (stream_left != 0) send_byte(rand_byte(), 1'b1);
    write_wrap(10'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.pending() != 0) $display("%0d expected items never arrived", sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
